// File: rtl/order_queue_position_tracker_unit_defines.svh
// Assertion macros shared by the checker files of the order queue position tracker.
`ifndef ORDER_QUEUE_POSITION_TRACKER_UNIT_DEFINES_SVH
`define ORDER_QUEUE_POSITION_TRACKER_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define OQPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define OQPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/oqpt_pkg.sv
// Package with constants, codes and types of the order queue position tracker.
`timescale 1ns / 1ps
package oqpt_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W = 64;
   localparam int SHARE_W = 32;
   localparam int PRICE_W = 32;
   localparam int TOTAL_W = 40;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_MUTATE = 2'd2;

   localparam logic [2:0] KIND_E = 3'd0;
   localparam logic [2:0] KIND_C = 3'd1;
   localparam logic [2:0] KIND_U = 3'd2;
   localparam logic [2:0] KIND_D = 3'd3;
   localparam logic [2:0] KIND_X = 3'd4;

   localparam logic [1:0] REASON_NONE = 2'd0;
   localparam logic [1:0] REASON_THROUGH = 2'd1;
   localparam logic [1:0] REASON_FACT = 2'd2;

   localparam logic [1:0] CSR_OWN_SIDE = 2'd0;
   localparam logic [1:0] CSR_LIMIT_PRICE = 2'd1;
   localparam logic [1:0] CSR_QUEUE_MODEL = 2'd2;

   localparam logic [1:0] MODEL_THROUGH = 2'd0;
   localparam logic [1:0] MODEL_FRONT = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_idx;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_idx;
      logic [KEY_W-1:0]   wr_key;
      logic [SHARE_W-1:0] wr_shares;
      logic               set_valid;
      logic               clr_valid;
      logic               clr_all;
   } tbl_ctl_type;
endpackage

// File: rtl/oqpt_table.sv
// Order table: key and share memory with one read and one write port plus valid bits.
`timescale 1ns / 1ps
module oqpt_table (
   input  logic                           clock,
   input  logic                           reset,
   input  oqpt_pkg::tbl_ctl_type          ctl,
   output logic                           rd_valid,
   output logic [oqpt_pkg::KEY_W-1:0]     rd_key,
   output logic [oqpt_pkg::SHARE_W-1:0]   rd_shares
);
   logic [oqpt_pkg::KEY_W+oqpt_pkg::SHARE_W-1:0] entry_mem_ff [oqpt_pkg::TABLE_DEPTH];
   logic [oqpt_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic rd_valid_ff;
   logic [oqpt_pkg::KEY_W+oqpt_pkg::SHARE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_mem_ff[ctl.wr_idx] <= {ctl.wr_key, ctl.wr_shares};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= entry_mem_ff[ctl.rd_idx];
         rd_valid_ff <= valid_ff[ctl.rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr_all) begin
         valid_ff <= '0;
      end else if (ctl.set_valid) begin
         valid_ff[ctl.wr_idx] <= 1'b1;
      end else if (ctl.clr_valid) begin
         valid_ff[ctl.wr_idx] <= 1'b0;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_key = rd_data_ff[oqpt_pkg::KEY_W+oqpt_pkg::SHARE_W-1:oqpt_pkg::SHARE_W];
   assign rd_shares = rd_data_ff[oqpt_pkg::SHARE_W-1:0];
endmodule

// File: rtl/order_queue_position_tracker_unit.sv
// Top level of the order queue position tracker.
`timescale 1ns / 1ps
// The block tracks how many shares rest ahead of a shadow limit order and
// turns feed words into fill evidence. The request channel carries one feed
// word per handshake (req_valid high, req_stall low); every request word gives
// exactly one response word on the rsp_ channel. The user must write the own
// side, the limit price and the queue model over the csr_ port only while the
// block is idle; the block itself does not enforce this.
// One word is worked on at a time. Clear words, loads that are ignored and
// mutations that need no table lookup go from acceptance through the
// evaluate and finish states to a valid response. Words that search the order
// table read one entry per cycle from the table memory through its single read
// port, then pass the update state: a hit ends the search at once, a miss only
// after all TABLE_DEPTH entries are read.
// The next word can be accepted in the cycle after a response is loaded.
// Reset clears all valid bits, the running total, the state and the CSR
// registers at once, with no clearing pass. A stalled response holds; the next
// request word is accepted while it waits, and its own result waits in the last
// state until the output register is free.
module order_queue_position_tracker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_command,
   input  logic                           req_feed_side,
   input  logic [2:0]                     req_message_kind,
   input  logic [31:0]                    req_price,
   input  logic [63:0]                    req_order_reference,
   input  logic [31:0]                    req_share_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_fill_quantity,
   output logic [1:0]                     rsp_fill_reason,
   output logic                           rsp_table_overflow,
   input  logic                           csr_write_enable,
   input  logic [1:0]                     csr_index,
   input  logic [31:0]                    csr_write_data
);
   oqpt_pkg::state_type state_ff, state_in;
   logic own_side_ff;
   logic [oqpt_pkg::PRICE_W-1:0] limit_ff;
   logic [1:0] model_ff;
   logic [1:0] cmd_ff;
   logic side_ff;
   logic [2:0] kind_ff;
   logic [oqpt_pkg::PRICE_W-1:0] price_ff;
   logic [oqpt_pkg::KEY_W-1:0] ref_ff;
   logic [oqpt_pkg::SHARE_W-1:0] qty_ff;
   logic [oqpt_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [oqpt_pkg::CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [oqpt_pkg::IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic chk_live_ff, chk_live_in;
   logic found_ff, found_in;
   logic [oqpt_pkg::IDX_W-1:0] slot_ff, slot_in;
   logic [oqpt_pkg::SHARE_W-1:0] hit_shares_ff, hit_shares_in;
   logic free_found_ff, free_found_in;
   logic [oqpt_pkg::IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [oqpt_pkg::SHARE_W-1:0] res_qty_ff, res_qty_in;
   logic [1:0] res_reason_ff, res_reason_in;
   logic res_ovf_ff, res_ovf_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [oqpt_pkg::SHARE_W-1:0] rsp_qty_ff;
   logic [1:0] rsp_reason_ff;
   logic rsp_ovf_ff;
   logic rsp_load;

   oqpt_pkg::tbl_ctl_type tbl_ctl;
   logic tbl_rd_valid;
   logic [oqpt_pkg::KEY_W-1:0] tbl_rd_key;
   logic [oqpt_pkg::SHARE_W-1:0] tbl_rd_shares;

   logic exec_w;
   logic through_w;
   logic at_limit_w;
   logic [oqpt_pkg::TOTAL_W:0] total_sum_w;
   logic [oqpt_pkg::SHARE_W-1:0] removed_w;
   logic [oqpt_pkg::SHARE_W-1:0] remain_w;
   logic [oqpt_pkg::TOTAL_W-1:0] sub_amt_w;

   oqpt_table u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tbl_ctl),
      .rd_valid  (tbl_rd_valid),
      .rd_key    (tbl_rd_key),
      .rd_shares (tbl_rd_shares)
   );

   assign req_stall = (state_ff != oqpt_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_side_ff <= 1'b0;
         limit_ff <= '0;
         model_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            oqpt_pkg::CSR_OWN_SIDE: own_side_ff <= csr_write_data[0];
            oqpt_pkg::CSR_LIMIT_PRICE: limit_ff <= csr_write_data;
            oqpt_pkg::CSR_QUEUE_MODEL: model_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff <= req_command;
         side_ff <= req_feed_side;
         kind_ff <= req_message_kind;
         price_ff <= req_price;
         ref_ff <= req_order_reference;
         qty_ff <= req_share_count;
      end
      rd_cnt_ff <= rd_cnt_in;
      chk_idx_ff <= chk_idx_in;
      slot_ff <= slot_in;
      hit_shares_ff <= hit_shares_in;
      free_idx_ff <= free_idx_in;
      res_qty_ff <= res_qty_in;
      res_reason_ff <= res_reason_in;
      res_ovf_ff <= res_ovf_in;
      found_ff <= found_in;
      free_found_ff <= free_found_in;
      if (rsp_load) begin
         rsp_qty_ff <= res_qty_ff;
         rsp_reason_ff <= res_reason_ff;
         rsp_ovf_ff <= res_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oqpt_pkg::ST_IDLE;
         total_ff <= '0;
         chk_live_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         chk_live_ff <= chk_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign exec_w = (kind_ff == oqpt_pkg::KIND_E) || (kind_ff == oqpt_pkg::KIND_C);
   assign through_w = own_side_ff ? (price_ff > limit_ff) : (price_ff < limit_ff);
   assign at_limit_w = (price_ff == limit_ff);
   assign total_sum_w = {1'b0, total_ff} + (oqpt_pkg::TOTAL_W + 1)'(qty_ff);
   assign removed_w = (hit_shares_ff < qty_ff) ? hit_shares_ff : qty_ff;
   assign remain_w = hit_shares_ff - removed_w;

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      rd_cnt_in = rd_cnt_ff;
      chk_idx_in = chk_idx_ff;
      chk_live_in = chk_live_ff;
      found_in = found_ff;
      slot_in = slot_ff;
      hit_shares_in = hit_shares_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      res_qty_in = res_qty_ff;
      res_reason_in = res_reason_ff;
      res_ovf_in = res_ovf_ff;
      rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tbl_ctl = '0;
      sub_amt_w = '0;

      case (state_ff)
         oqpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = oqpt_pkg::ST_EVAL;
            end
         end
         oqpt_pkg::ST_EVAL: begin
            res_qty_in = '0;
            res_reason_in = oqpt_pkg::REASON_NONE;
            res_ovf_in = 1'b0;
            rd_cnt_in = '0;
            chk_live_in = 1'b0;
            found_in = 1'b0;
            free_found_in = 1'b0;
            state_in = oqpt_pkg::ST_FINISH;
            case (cmd_ff)
               oqpt_pkg::CMD_CLEAR: begin
                  tbl_ctl.clr_all = 1'b1;
                  total_in = '0;
               end
               oqpt_pkg::CMD_LOAD: begin
                  if (model_ff[1] && (side_ff == own_side_ff) && at_limit_w) begin
                     state_in = oqpt_pkg::ST_SCAN;
                  end
               end
               oqpt_pkg::CMD_MUTATE: begin
                  if (side_ff != own_side_ff) begin
                     state_in = oqpt_pkg::ST_FINISH;
                  end else if (exec_w && through_w) begin
                     res_qty_in = qty_ff;
                     res_reason_in = oqpt_pkg::REASON_THROUGH;
                  end else if ((!at_limit_w && (kind_ff != oqpt_pkg::KIND_U))
                               || (model_ff == oqpt_pkg::MODEL_THROUGH)) begin
                     state_in = oqpt_pkg::ST_FINISH;
                  end else if (model_ff == oqpt_pkg::MODEL_FRONT) begin
                     if (exec_w && at_limit_w) begin
                        res_qty_in = qty_ff;
                        res_reason_in = oqpt_pkg::REASON_FACT;
                     end
                  end else begin
                     state_in = oqpt_pkg::ST_SCAN;
                  end
               end
               default: ;
            endcase
         end
         oqpt_pkg::ST_SCAN: begin
            tbl_ctl.rd_en = (rd_cnt_ff < oqpt_pkg::CNT_W'(oqpt_pkg::TABLE_DEPTH));
            tbl_ctl.rd_idx = rd_cnt_ff[oqpt_pkg::IDX_W-1:0];
            chk_live_in = tbl_ctl.rd_en;
            chk_idx_in = rd_cnt_ff[oqpt_pkg::IDX_W-1:0];
            if (tbl_ctl.rd_en) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (chk_live_ff && !tbl_rd_valid && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in = chk_idx_ff;
            end
            if (chk_live_ff && tbl_rd_valid && (tbl_rd_key == ref_ff)) begin
               found_in = 1'b1;
               slot_in = chk_idx_ff;
               hit_shares_in = tbl_rd_shares;
               chk_live_in = 1'b0;
               state_in = oqpt_pkg::ST_UPDATE;
            end else if (!chk_live_ff
                         && (rd_cnt_ff == oqpt_pkg::CNT_W'(oqpt_pkg::TABLE_DEPTH))) begin
               state_in = oqpt_pkg::ST_UPDATE;
            end
         end
         oqpt_pkg::ST_UPDATE: begin
            state_in = oqpt_pkg::ST_FINISH;
            if (cmd_ff == oqpt_pkg::CMD_LOAD) begin
               if (!found_ff) begin
                  if (free_found_ff) begin
                     tbl_ctl.wr_en = 1'b1;
                     tbl_ctl.set_valid = 1'b1;
                     tbl_ctl.wr_idx = free_idx_ff;
                     tbl_ctl.wr_key = ref_ff;
                     tbl_ctl.wr_shares = qty_ff;
                     total_in = total_sum_w[oqpt_pkg::TOTAL_W]
                                ? {oqpt_pkg::TOTAL_W{1'b1}}
                                : total_sum_w[oqpt_pkg::TOTAL_W-1:0];
                  end else begin
                     res_ovf_in = 1'b1;
                  end
               end
            end else begin
               if (found_ff && ((kind_ff == oqpt_pkg::KIND_U)
                                || (kind_ff == oqpt_pkg::KIND_D))) begin
                  sub_amt_w = oqpt_pkg::TOTAL_W'(hit_shares_ff);
                  total_in = (sub_amt_w >= total_ff) ? '0 : total_ff - sub_amt_w;
                  tbl_ctl.clr_valid = 1'b1;
                  tbl_ctl.wr_idx = slot_ff;
               end else if (found_ff && (exec_w || (kind_ff == oqpt_pkg::KIND_X))) begin
                  sub_amt_w = oqpt_pkg::TOTAL_W'(removed_w);
                  total_in = (sub_amt_w >= total_ff) ? '0 : total_ff - sub_amt_w;
                  tbl_ctl.wr_en = 1'b1;
                  tbl_ctl.wr_idx = slot_ff;
                  tbl_ctl.wr_key = ref_ff;
                  tbl_ctl.wr_shares = remain_w;
                  tbl_ctl.clr_valid = (remain_w == '0);
               end else if (exec_w && at_limit_w && (total_ff == '0)) begin
                  res_qty_in = qty_ff;
                  res_reason_in = oqpt_pkg::REASON_FACT;
               end
            end
         end
         oqpt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = oqpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = oqpt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fill_quantity = rsp_qty_ff;
   assign rsp_fill_reason = rsp_reason_ff;
   assign rsp_table_overflow = rsp_ovf_ff;
endmodule

// File: rtl/oqpt_checker.sv
// Port checker of the order queue position tracker and its bind statement.
`timescale 1ns / 1ps
`include "order_queue_position_tracker_unit_defines.svh"
module oqpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_command,
   input logic        req_feed_side,
   input logic [2:0]  req_message_kind,
   input logic [31:0] req_price,
   input logic [63:0] req_order_reference,
   input logic [31:0] req_share_count,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_fill_quantity,
   input logic [1:0]  rsp_fill_reason,
   input logic        rsp_table_overflow,
   input logic        csr_write_enable,
   input logic [1:0]  csr_index,
   input logic [31:0] csr_write_data
);
   `OQPT_ASSERT(busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall, "block took a second word while the first was at work")
   `OQPT_ASSERT(rsp_held, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_fill_quantity) && $stable(rsp_fill_reason) && $stable(rsp_table_overflow)), "stalled response word changed")
   `OQPT_ASSERT(overflow_no_fill, clock, reset, (rsp_valid && rsp_table_overflow) |-> ((rsp_fill_quantity == 32'd0) && (rsp_fill_reason == oqpt_pkg::REASON_NONE)), "overflow word carries fill evidence")
   `OQPT_ASSERT(no_reason_no_qty, clock, reset, (rsp_valid && (rsp_fill_reason == oqpt_pkg::REASON_NONE)) |-> (rsp_fill_quantity == 32'd0), "fill quantity without a reason")
   `OQPT_ASSERT_ALWAYS(idle_after_reset, clock, $past(reset) |-> (!rsp_valid && !req_stall), "block not idle after reset")
endmodule

bind order_queue_position_tracker_unit oqpt_checker u_oqpt_checker (.*);
